// ----- sv/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- sv/cfrl_pkg.sv -----
// shared types and constants of the fifo/lru replacement cache model
package cfrl_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int SLOT_BITS   = $clog2(MAX_ENTRIES);
    localparam int BLOCK_BITS  = 7;
    localparam int COUNT_BITS  = 32;
    localparam int ENTRY_BITS  = 6;
    localparam int MEM_BITS    = 8;
    localparam int CFG_BITS    = 2;

    localparam logic [ENTRY_BITS-1:0] ENTRIES_RESET = 6'd4;
    localparam logic [ENTRY_BITS-1:0] ENTRIES_MAX   = 6'd32;
    localparam logic [MEM_BITS-1:0]   MEM_RESET     = 8'd32;

    typedef enum logic [CFG_BITS-1:0] {
        CFG_CACHE_ENTRIES = 2'd0,
        CFG_MEM_BLOCKS    = 2'd1,
        CFG_POLICY        = 2'd2
    } cfg_index_t;

    typedef enum logic {
        POLICY_FIFO = 1'b0,
        POLICY_LRU  = 1'b1
    } policy_t;

    // control of the tag store from the sequencer
    typedef struct packed {
        logic [SLOT_BITS-1:0]  rd_addr;
        logic                  wr_en;
        logic [SLOT_BITS-1:0]  wr_addr;
        logic [BLOCK_BITS-1:0] wr_tag;
        logic                  wr_vld;
    } tag_ctrl_t;

endpackage

// ----- sv/cache_replacement_fifo_lru.sv -----
// top level: fully associative cache hit model with fifo or lru replacement
// usage
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): write only while
//   the block is idle; index 0 cache_entries, 1 mem_blocks, 2 policy, 3 ignored
//   request channel (req_valid/req_stall, block_ref): one item per block reference
//   response channel (rsp_valid/rsp_stall, hit, bad_ref, hit_count, ref_count)
// operation
//   a bad reference is answered from the done step without a scan
//   otherwise the scan reads one tag slot at a time, a read step then a compare
//   step, through the single read port of the tag store, stopping at the first
//   match or at the last slot in use; a fifo miss adds a write step, lru adds a
//   read and a write step per slot moved plus a step for the front write
//   the next item is taken once the previous one has been handed to the
//   response register, so a stalled response overlaps with the next item
// reset
//   all slots invalid, fifo pointer and totals zero, 4 slots, 32 blocks, fifo
// stall
//   a held response keeps its fields; a finished item waits until it frees
module cache_replacement_fifo_lru (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfrl_pkg::CFG_BITS-1:0]     cfg_index,
    input  logic [cfrl_pkg::MEM_BITS-1:0]     cfg_data,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [cfrl_pkg::BLOCK_BITS-1:0]   block_ref,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic                              hit,
    output logic                              bad_ref,
    output logic [cfrl_pkg::COUNT_BITS-1:0]   hit_count,
    output logic [cfrl_pkg::COUNT_BITS-1:0]   ref_count
);
    import cfrl_pkg::*;

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FIFO_WR,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FRONT_WR,
        ST_DONE
    } state_t;

    // configuration registers
    logic [ENTRY_BITS-1:0] entries_reg;
    logic [MEM_BITS-1:0]   mem_blocks_reg;
    logic                  policy_reg;

    // sequencer state and working registers
    state_t                state_reg, state_next;
    logic [BLOCK_BITS-1:0] blk_reg, blk_next;
    logic                  bad_reg, bad_next;
    logic                  found_reg, found_next;
    logic [SLOT_BITS-1:0]  idx_reg, idx_next;
    logic [SLOT_BITS-1:0]  fifo_ptr_reg, fifo_ptr_next;
    logic [COUNT_BITS-1:0] hits_reg, hits_next;
    logic [COUNT_BITS-1:0] refs_reg, refs_next;

    // response register
    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  hit_reg, hit_next;
    logic                  bad_ref_reg, bad_ref_next;
    logic [COUNT_BITS-1:0] hit_count_reg, hit_count_next;
    logic [COUNT_BITS-1:0] ref_count_reg, ref_count_next;

    tag_ctrl_t             ctrl;
    logic [BLOCK_BITS-1:0] rd_tag;
    logic                  rd_vld;

    logic [ENTRY_BITS-1:0] n_eff;
    logic [ENTRY_BITS-1:0] n_minus;
    logic [SLOT_BITS-1:0]  last_idx;
    logic [SLOT_BITS-1:0]  fifo_slot;
    logic [ENTRY_BITS-1:0] fifo_inc;
    logic [SLOT_BITS-1:0]  idx_dec;
    logic                  match;
    logic                  scan_end;
    logic [SLOT_BITS-1:0]  lru_start;
    logic [COUNT_BITS-1:0] hits_bump;
    logic [COUNT_BITS-1:0] refs_bump;

    // config port always ready, writes beyond the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg    <= ENTRIES_RESET;
            mem_blocks_reg <= MEM_RESET;
            policy_reg     <= POLICY_FIFO;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CACHE_ENTRIES: entries_reg    <= cfg_data[ENTRY_BITS-1:0];
                CFG_MEM_BLOCKS:    mem_blocks_reg <= cfg_data;
                CFG_POLICY:        policy_reg     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // slots in use: zero acts as one, oversize clamps to the store depth
    always_comb
    begin
        if (entries_reg == '0)
        begin
            n_eff = 6'd1;
        end
        else if (entries_reg > ENTRIES_MAX)
        begin
            n_eff = ENTRIES_MAX;
        end
        else
        begin
            n_eff = entries_reg;
        end
    end

    assign n_minus  = n_eff - 6'd1;
    assign last_idx = n_minus[SLOT_BITS-1:0];

    // stale pointer after a shrink restarts from slot 0
    assign fifo_slot = ({1'b0, fifo_ptr_reg} < n_eff) ? fifo_ptr_reg : '0;
    assign fifo_inc  = {1'b0, fifo_slot} + 6'd1;

    assign idx_dec   = idx_reg - 5'd1;
    assign match     = rd_vld && (rd_tag == blk_reg);
    assign scan_end  = (idx_reg == last_idx);
    // lru moves everything up to the hit slot, or the whole used range on a miss
    assign lru_start = match ? idx_reg : last_idx;

    // saturating totals
    assign hits_bump = (hits_reg == '1) ? hits_reg : hits_reg + 32'd1;
    assign refs_bump = (refs_reg == '1) ? refs_reg : refs_reg + 32'd1;

    always_comb
    begin
        state_next     = state_reg;
        blk_next       = blk_reg;
        bad_next       = bad_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        fifo_ptr_next  = fifo_ptr_reg;
        hits_next      = hits_reg;
        refs_next      = refs_reg;
        rsp_valid_next = rsp_valid_reg;
        hit_next       = hit_reg;
        bad_ref_next   = bad_ref_reg;
        hit_count_next = hit_count_reg;
        ref_count_next = ref_count_reg;
        ctrl           = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    blk_next   = block_ref;
                    bad_next   = ({1'b0, block_ref} >= mem_blocks_reg);
                    found_next = 1'b0;
                    idx_next   = '0;
                    state_next = ({1'b0, block_ref} >= mem_blocks_reg) ? ST_DONE
                                                                        : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                ctrl.rd_addr = idx_reg;
                state_next   = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (match || scan_end)
                begin
                    found_next = match;
                    if (policy_reg == POLICY_LRU)
                    begin
                        idx_next   = lru_start;
                        state_next = (lru_start == '0) ? ST_FRONT_WR : ST_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = match ? ST_DONE : ST_FIFO_WR;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 5'd1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FIFO_WR:
            begin
                ctrl.wr_en    = 1'b1;
                ctrl.wr_addr  = fifo_slot;
                ctrl.wr_tag   = blk_reg;
                ctrl.wr_vld   = 1'b1;
                fifo_ptr_next = (fifo_inc >= n_eff) ? '0 : fifo_inc[SLOT_BITS-1:0];
                state_next    = ST_DONE;
            end
            ST_SHIFT_RD:
            begin
                ctrl.rd_addr = idx_dec;
                state_next   = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                // slot k takes what slot k-1 held, flag included
                ctrl.wr_en   = 1'b1;
                ctrl.wr_addr = idx_reg;
                ctrl.wr_tag  = rd_tag;
                ctrl.wr_vld  = rd_vld;
                idx_next     = idx_dec;
                state_next   = (idx_dec == '0) ? ST_FRONT_WR : ST_SHIFT_RD;
            end
            ST_FRONT_WR:
            begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_addr = '0;
                ctrl.wr_tag  = blk_reg;
                ctrl.wr_vld  = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    hit_next       = found_reg && !bad_reg;
                    bad_ref_next   = bad_reg;
                    if (bad_reg)
                    begin
                        hit_count_next = hits_reg;
                        ref_count_next = refs_reg;
                    end
                    else
                    begin
                        refs_next      = refs_bump;
                        ref_count_next = refs_bump;
                        hits_next      = found_reg ? hits_bump : hits_reg;
                        hit_count_next = found_reg ? hits_bump : hits_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            blk_reg       <= '0;
            bad_reg       <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            fifo_ptr_reg  <= '0;
            hits_reg      <= '0;
            refs_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            bad_ref_reg   <= 1'b0;
            hit_count_reg <= '0;
            ref_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            blk_reg       <= blk_next;
            bad_reg       <= bad_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
            fifo_ptr_reg  <= fifo_ptr_next;
            hits_reg      <= hits_next;
            refs_reg      <= refs_next;
            rsp_valid_reg <= rsp_valid_next;
            hit_reg       <= hit_next;
            bad_ref_reg   <= bad_ref_next;
            hit_count_reg <= hit_count_next;
            ref_count_reg <= ref_count_next;
        end
    end

    cfrl_tag_store u_tag_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .rd_tag (rd_tag),
        .rd_vld (rd_vld)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign hit       = hit_reg;
    assign bad_ref   = bad_ref_reg;
    assign hit_count = hit_count_reg;
    assign ref_count = ref_count_reg;

    `ASSERT_NEVER(a_hit_and_bad, clk, rst_n, rsp_valid && hit && bad_ref,
        "hit reported on a bad item")
    `ASSERT_PROP(a_hits_le_refs, clk, rst_n, rsp_valid |-> (hit_count <= ref_count),
        "hit total above reference total")
    `ASSERT_PROP(a_shift_nonzero, clk, rst_n, (state_reg == ST_SHIFT_RD) |-> (idx_reg != '0),
        "lru shift reached slot zero")
    `ASSERT_PROP(a_rsp_from_done, clk, rst_n,
        $rose(rsp_valid) |-> $past(state_reg == ST_DONE),
        "response raised outside the done step")

endmodule

// ----- sv/cfrl_tag_store.sv -----
// tag memory with per-slot valid flags, one write and one registered read a cycle
module cfrl_tag_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfrl_pkg::tag_ctrl_t           ctrl,
    output logic [cfrl_pkg::BLOCK_BITS-1:0] rd_tag,
    output logic                          rd_vld
);
    import cfrl_pkg::*;

    logic [BLOCK_BITS-1:0]  tag_mem [MAX_ENTRIES];
    logic [BLOCK_BITS-1:0]  rd_tag_reg;
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic                   rd_vld_reg;

    // tag contents need no reset, the valid flag guards them
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            tag_mem[ctrl.wr_addr] <= ctrl.wr_tag;
        end
        rd_tag_reg <= tag_mem[ctrl.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.wr_en)
            begin
                valid_reg[ctrl.wr_addr] <= ctrl.wr_vld;
            end
            rd_vld_reg <= valid_reg[ctrl.rd_addr];
        end
    end

    assign rd_tag = rd_tag_reg;
    assign rd_vld = rd_vld_reg;

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the fifo/lru replacement cache hit model
`timescale 1ns / 100ps

module testbench;

    import cfrl_pkg::*;

    // ------------------------------------------------------------------
    // run constants
    // ------------------------------------------------------------------
    localparam int RANDOM_REFS  = 1100;     // random references after the directed rows
    localparam int IDLE_LIMIT   = 2000;     // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 200;      // quiet time at the end, above one lru miss at 32 slots
    localparam int MAX_GAP      = 17;       // longest idle or stall drawn per item

    // register index 3 exists on the port but selects nothing
    localparam logic [CFG_BITS-1:0] CFG_SPARE = 2'd3;
    // filler index for rows that carry a reference
    localparam logic [CFG_BITS-1:0] NO_REG    = 2'd0;

    // one response as seen on the result port
    typedef struct packed {
        logic                  hit;
        logic                  bad_ref;
        logic [COUNT_BITS-1:0] hit_count;
        logic [COUNT_BITS-1:0] ref_count;
    } cache_rsp_t;

    localparam cache_rsp_t NO_RSP = '0;

    // directed rows either write a register or send one reference
    typedef enum logic {
        ROW_REF,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [CFG_BITS-1:0] reg_idx;
        logic [MEM_BITS-1:0] value;     // register data, or the block number in the low bits
        logic                typed;     // expected response is written in the row
        cache_rsp_t          want;
    } stim_row_t;

    // ------------------------------------------------------------------
    // clock, reset and dut ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_BITS-1:0]   cfg_index = '0;
    logic [MEM_BITS-1:0]   cfg_data  = '0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic [BLOCK_BITS-1:0] block_ref = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic                  hit;
    logic                  bad_ref;
    logic [COUNT_BITS-1:0] hit_count;
    logic [COUNT_BITS-1:0] ref_count;

    always #5 clk = ~clk;

    cache_replacement_fifo_lru i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .block_ref (block_ref),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .hit       (hit),
        .bad_ref   (bad_ref),
        .hit_count (hit_count),
        .ref_count (ref_count)
    );

    // ------------------------------------------------------------------
    // shadow copy of the cache: registers, tags and running totals
    // ------------------------------------------------------------------
    logic [ENTRY_BITS-1:0] shadow_entries;
    logic [MEM_BITS-1:0]   shadow_mem;
    policy_t               shadow_policy;
    logic [BLOCK_BITS-1:0] shadow_tag   [MAX_ENTRIES];
    logic                  shadow_valid [MAX_ENTRIES];
    int                    shadow_fifo_ptr;
    logic [COUNT_BITS-1:0] shadow_hits;
    logic [COUNT_BITS-1:0] shadow_refs;

    // responses still owed by the dut, oldest first
    cache_rsp_t pending_rsp [$];

    // bookkeeping
    int  fail_count  = 0;
    int  refs_sent   = 0;
    int  hits_seen   = 0;
    int  bad_seen    = 0;
    int  reg_writes  = 0;
    int  phase_count = 0;
    int  idle_cycles = 0;
    int  stall_left  = 0;
    bit  req_calm    = 1'b0;    // sender sends back to back this phase
    bit  rsp_calm    = 1'b0;    // receiver never stalls this phase
    int  ws_base;               // working set that keeps the hit rate up
    int  ws_size;

    // ------------------------------------------------------------------
    // directed rows: reset state, out-of-range references, fifo wrap and
    // eviction, lru reorder, cache size of zero and above the maximum,
    // fifo pointer beyond a shrunk cache, memory size of zero and of 255,
    // the unused register index
    // ------------------------------------------------------------------
    stim_row_t directed_rows [34] = '{
        // reset config: 4 slots, 32 blocks, fifo
        '{ROW_REF, NO_REG, 8'd0,   1'b1, '{1'b0, 1'b0, 32'd0, 32'd1}},  // cold miss
        '{ROW_REF, NO_REG, 8'd0,   1'b1, '{1'b1, 1'b0, 32'd1, 32'd2}},  // same block hits
        '{ROW_REF, NO_REG, 8'd32,  1'b1, '{1'b0, 1'b1, 32'd1, 32'd2}},  // first block past memory
        '{ROW_REF, NO_REG, 8'd127, 1'b1, '{1'b0, 1'b1, 32'd1, 32'd2}},  // largest block number
        '{ROW_REF, NO_REG, 8'd31,  1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd1,   1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd2,   1'b0, NO_RSP},                      // cache now full
        '{ROW_REF, NO_REG, 8'd3,   1'b0, NO_RSP},                      // round robin wraps
        '{ROW_REF, NO_REG, 8'd0,   1'b0, NO_RSP},                      // evicted block misses
        // switch to lru with the fifo contents kept
        '{ROW_CFG, CFG_POLICY, 8'd1, 1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd3,   1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd5,   1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd31,  1'b0, NO_RSP},
        // upper data bits dropped, size 0 acts as one slot
        '{ROW_CFG, CFG_CACHE_ENTRIES, 8'hC0, 1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd31,  1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd30,  1'b0, NO_RSP},
        // size above the maximum acts as 32, full memory
        '{ROW_CFG, CFG_CACHE_ENTRIES, 8'd63, 1'b0, NO_RSP},
        '{ROW_CFG, CFG_MEM_BLOCKS, 8'd128, 1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd127, 1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd64,  1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd30,  1'b0, NO_RSP},                      // stale copies beyond slot 0
        // back to fifo on a small cache, pointer may sit past the end
        '{ROW_CFG, CFG_POLICY, 8'd0, 1'b0, NO_RSP},
        '{ROW_CFG, CFG_CACHE_ENTRIES, 8'd2, 1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd100, 1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd101, 1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd102, 1'b0, NO_RSP},
        // no memory at all: every reference is out of range
        '{ROW_CFG, CFG_MEM_BLOCKS, 8'd0, 1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd0,   1'b0, NO_RSP},
        // raw compare against 255, then a write that selects nothing
        '{ROW_CFG, CFG_MEM_BLOCKS, 8'd255, 1'b0, NO_RSP},
        '{ROW_CFG, CFG_SPARE, 8'hFF, 1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd127, 1'b0, NO_RSP},
        '{ROW_CFG, CFG_MEM_BLOCKS, 8'd64, 1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd64,  1'b0, NO_RSP},
        '{ROW_REF, NO_REG, 8'd63,  1'b0, NO_RSP}
    };

    // ------------------------------------------------------------------
    // cache predictor
    // ------------------------------------------------------------------
    function automatic int live_slots();
        if (shadow_entries == 0)
            return 1;
        if (shadow_entries > MAX_ENTRIES)
            return MAX_ENTRIES;
        return int'(shadow_entries);
    endfunction

    // looks one block up in the shadow cache, applies the replacement and
    // returns the response the dut must give
    function automatic cache_rsp_t cache_lookup(logic [BLOCK_BITS-1:0] blk);
        cache_rsp_t rsp;
        int         n;
        int         where;
        int         k;
        int         p;
        bit         found;

        n     = live_slots();
        found = 1'b0;
        where = 0;
        rsp   = NO_RSP;

        // out of range: totals shown, nothing moves
        if ({1'b0, blk} >= shadow_mem) begin
            rsp.bad_ref   = 1'b1;
            rsp.hit_count = shadow_hits;
            rsp.ref_count = shadow_refs;
            return rsp;
        end

        // lowest matching slot wins when duplicates exist
        for (int i = 0; i < n; i++) begin
            if (!found && shadow_valid[i] && shadow_tag[i] == blk) begin
                found = 1'b1;
                where = i;
            end
        end

        if (shadow_policy == POLICY_FIFO) begin
            if (!found) begin
                p = (shadow_fifo_ptr < n) ? shadow_fifo_ptr : 0;
                shadow_tag[p]   = blk;
                shadow_valid[p] = 1'b1;
                p++;
                shadow_fifo_ptr = (p >= n) ? 0 : p;
            end
        end
        else begin
            // move toward the back up to the hit slot, or drop the last slot
            k = found ? where : n - 1;
            while (k > 0) begin
                shadow_tag[k]   = shadow_tag[k-1];
                shadow_valid[k] = shadow_valid[k-1];
                k--;
            end
            shadow_tag[0]   = blk;
            shadow_valid[0] = 1'b1;
        end

        if (found && shadow_hits != '1)
            shadow_hits++;
        if (shadow_refs != '1)
            shadow_refs++;

        rsp.hit       = found;
        rsp.hit_count = shadow_hits;
        rsp.ref_count = shadow_refs;
        return rsp;
    endfunction

    function automatic void shadow_write(logic [CFG_BITS-1:0] idx, logic [MEM_BITS-1:0] data);
        case (idx)
            CFG_CACHE_ENTRIES: shadow_entries = data[ENTRY_BITS-1:0];
            CFG_MEM_BLOCKS:    shadow_mem     = data;
            CFG_POLICY:        shadow_policy  = policy_t'(data[0]);
            default:           ;
        endcase
    endfunction

    // most references fall in a working set so both hits and evictions
    // happen; the rest spread over memory or go past its end
    function automatic logic [BLOCK_BITS-1:0] next_block();
        int roll;
        int span;

        roll = $urandom_range(0, 99);
        span = (shadow_mem > 128) ? 128 : int'(shadow_mem);
        if (roll < 70 && span > 0)
            return BLOCK_BITS'((ws_base + $urandom_range(0, ws_size - 1)) % span);
        if (roll < 90 && span > 0)
            return BLOCK_BITS'($urandom_range(0, span - 1));
        return BLOCK_BITS'($urandom_range(0, 127));
    endfunction

    // ------------------------------------------------------------------
    // driving tasks
    // ------------------------------------------------------------------

    // sends one reference; valid stays high when the drawn gap is zero so the
    // next item follows back to back
    task automatic send_ref(logic [BLOCK_BITS-1:0] blk, logic typed, cache_rsp_t want);
        cache_rsp_t predicted;
        int         gap;

        req_valid <= 1'b1;
        block_ref <= blk;
        do
            @(posedge clk);
        while (req_stall);
        predicted = cache_lookup(blk);
        pending_rsp.push_back(typed ? want : predicted);
        refs_sent++;

        gap = req_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stops sending and waits until every owed response has come back
    task automatic settle();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one register write; valid is left high, the caller drops it after
    // the last write of a batch
    task automatic write_reg(logic [CFG_BITS-1:0] idx, logic [MEM_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_write(idx, data);
        reg_writes++;
    endtask

    // ------------------------------------------------------------------
    // response side: random stall per item, check against the oldest owed
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [COUNT_BITS-1:0] want,
                                        logic [COUNT_BITS-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    cache_rsp_t oldest;

    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
                $error("response with no reference outstanding");
                fail_count++;
            end
            else begin
                oldest = pending_rsp.pop_front();
                check_field("hit", COUNT_BITS'(oldest.hit), COUNT_BITS'(hit));
                check_field("bad_ref", COUNT_BITS'(oldest.bad_ref), COUNT_BITS'(bad_ref));
                check_field("hit_count", oldest.hit_count, hit_count);
                check_field("ref_count", oldest.ref_count, ref_count);
            end
            hits_seen  += int'(hit === 1'b1);
            bad_seen   += int'(bad_ref === 1'b1);
            stall_left  = rsp_calm ? 0 : $urandom_range(0, MAX_GAP);
        end
        else if (stall_left > 0) begin
            stall_left--;
        end
        rsp_stall <= (stall_left > 0);
    end

    // ------------------------------------------------------------------
    // watchdog: any handshake restarts the count
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int                  left;
        int                  burst;
        int                  sz;
        logic [MEM_BITS-1:0] ent_data;
        logic [MEM_BITS-1:0] mem_data;
        logic [MEM_BITS-1:0] pol_data;
        int                  roll;

        // shadow state after reset
        shadow_entries  = ENTRIES_RESET;
        shadow_mem      = MEM_RESET;
        shadow_policy   = POLICY_FIFO;
        shadow_fifo_ptr = 0;
        shadow_hits     = '0;
        shadow_refs     = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            shadow_tag[i]   = '0;
            shadow_valid[i] = 1'b0;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
                cfg_valid <= 1'b0;
            end
            else begin
                send_ref(directed_rows[i].value[BLOCK_BITS-1:0], directed_rows[i].typed,
                         directed_rows[i].want);
            end
        end

        // random phases, each with its own register setting; the first
        // four pin the extremes
        left = RANDOM_REFS;
        while (left > 0) begin
            case (phase_count)
                0: begin ent_data = 8'd32;  mem_data = 8'd128; pol_data = 8'd1; end
                1: begin ent_data = 8'd1;   mem_data = 8'd32;  pol_data = 8'd0; end
                2: begin ent_data = 8'h40;  mem_data = 8'd255; pol_data = 8'd1; end
                3: begin ent_data = 8'd63;  mem_data = 8'd64;  pol_data = 8'hFE; end
                default: begin
                    roll = $urandom_range(0, 99);
                    if (roll < 8)
                        sz = 0;
                    else if (roll < 18)
                        sz = $urandom_range(33, 63);
                    else
                        sz = $urandom_range(1, 32);
                    ent_data = MEM_BITS'($urandom_range(0, 255) & 8'hC0) | MEM_BITS'(sz);
                    roll = $urandom_range(0, 99);
                    if (roll < 70)
                        mem_data = MEM_BITS'(32 << $urandom_range(0, 2));
                    else if (roll < 80)
                        mem_data = MEM_BITS'($urandom_range(0, 31));
                    else if (roll < 90)
                        mem_data = MEM_BITS'($urandom_range(129, 255));
                    else
                        mem_data = MEM_BITS'($urandom_range(0, 255));
                    pol_data = MEM_BITS'($urandom_range(0, 255));
                end
            endcase

            settle();
            write_reg(CFG_CACHE_ENTRIES, ent_data);
            write_reg(CFG_MEM_BLOCKS, mem_data);
            write_reg(CFG_POLICY, pol_data);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE, MEM_BITS'($urandom_range(0, 255)));
            cfg_valid <= 1'b0;
            phase_count++;

            // working set a little above or below the cache size
            ws_base  = $urandom_range(0, 127);
            ws_size  = $urandom_range(1, live_slots() + 4);
            req_calm = ($urandom_range(0, 3) == 0);
            rsp_calm = ($urandom_range(0, 3) == 0);

            burst = $urandom_range(30, 80);
            if (burst > left)
                burst = left;
            for (int j = 0; j < burst; j++)
                send_ref(next_block(), 1'b0, NO_RSP);
            left -= burst;
        end

        // drain and make sure nothing else comes out
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d references: %0d hits, %0d out of range, %0d register phases",
                 refs_sent, hits_seen, bad_seen, phase_count);
        $display("%0d register writes across fifo and lru, sizes 0..63, memory 0..255",
                 reg_writes);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
